### rtl/mfpf_pkg.sv
// Shared types, constants and helper functions for the multi-frame pixel fuse core.
// Holds the sample vector type, the sorting-network layers and the reciprocal table.
// No dependencies; every rtl file imports this package.
package mfpf_pkg;

    localparam int MAX_FRAMES = 8;
    localparam int SAMP_W     = 8;
    localparam int CNT_W      = 4;                   // holds 0..MAX_FRAMES
    localparam int IDX_W      = 3;                   // index into the sample vector
    localparam int SUM_W      = 11;                  // 8 * 255 fits in 11 bits
    localparam int RECIP_W    = 17;                  // ceil(2^16 / d), d = 1 needs 17 bits
    localparam int RECIP_SH   = 16;
    localparam int IN_W       = MAX_FRAMES * SAMP_W;
    localparam int OUT_W      = SAMP_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] IDX_FUSE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_FRAMES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_DROP_PCT  = 2'd2;

    // Fuse modes (the unused code behaves as mean)
    localparam logic [1:0] MODE_MEAN    = 2'd0;
    localparam logic [1:0] MODE_MEDIAN  = 2'd1;
    localparam logic [1:0] MODE_TRIMMED = 2'd2;

    // Register reset values
    localparam logic [1:0]       RST_FUSE_MODE = MODE_MEAN;
    localparam logic [CNT_W-1:0] RST_FRAMES    = 4'd5;
    localparam logic [5:0]       RST_DROP_PCT  = 6'd20;

    typedef logic [MAX_FRAMES-1:0][SAMP_W-1:0] samp_vec_t;

    // Values derived from the configuration registers
    typedef struct packed {
        logic               median;   // output the middle element
        logic [CNT_W-1:0]   lo;       // first sorted index in the sum
        logic [CNT_W-1:0]   hi;       // one past the last sorted index in the sum
        logic [CNT_W-1:0]   cnt;      // divisor, hi - lo
        logic [IDX_W-1:0]   half;     // median index, N / 2
        logic [RECIP_W-1:0] recip;    // ceil(2^16 / cnt)
    } drv_t;

    // Compare-exchange of two elements, ascending
    function automatic samp_vec_t cas(samp_vec_t v, int a, int b);
        samp_vec_t r;
        r = v;
        if (v[a] > v[b]) begin
            r[a] = v[b];
            r[b] = v[a];
        end
        return r;
    endfunction

    // Odd-even merge sort of eight, first three layers
    function automatic samp_vec_t sort_front(samp_vec_t v);
        samp_vec_t r;
        r = v;
        r = cas(r, 0, 1); r = cas(r, 2, 3); r = cas(r, 4, 5); r = cas(r, 6, 7);
        r = cas(r, 0, 2); r = cas(r, 1, 3); r = cas(r, 4, 6); r = cas(r, 5, 7);
        r = cas(r, 1, 2); r = cas(r, 5, 6);
        return r;
    endfunction

    // Odd-even merge sort of eight, last three layers
    function automatic samp_vec_t sort_back(samp_vec_t v);
        samp_vec_t r;
        r = v;
        r = cas(r, 0, 4); r = cas(r, 1, 5); r = cas(r, 2, 6); r = cas(r, 3, 7);
        r = cas(r, 2, 4); r = cas(r, 3, 5);
        r = cas(r, 1, 2); r = cas(r, 3, 4); r = cas(r, 5, 6);
        return r;
    endfunction

    // Reciprocal for exact floor division of sums below 2^SUM_W
    function automatic logic [RECIP_W-1:0] recip_of(logic [CNT_W-1:0] d);
        logic [RECIP_W-1:0] r;
        unique case (d)
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

### rtl/multi_frame_pixel_fuse_core.sv
// Multi-frame pixel fuse: mean, median or trimmed mean of up to eight co-located samples.
// Top level; instantiates mfpf_sort and depends on mfpf_pkg.
//
// Usage:
//   s_ channel: one beat per pixel channel, s_tdata holds sample_0..sample_7.
//   m_ channel: one beat per input beat, m_tdata holds fused_value.
//   cfg_we/cfg_index/cfg_wdata write fuse_mode (0), frames_in_use (1) and
//   drop_percent (2); write only while no beat is in flight.
// Pipeline: a result passes the input register, two sorter stages, select/sum,
//   reciprocal multiply and round before it appears on m_tvalid.
// Throughput: one beat per cycle while m_tready is high; every stage is a register
//   stage with its own valid bit.
// Stall: when m_tready is low the output beat holds and earlier stages keep
//   filling empty slots; s_tready drops only once all six stages are full.
// Reset: aresetn (synchronous, active low) empties the pipeline and loads
//   fuse_mode 0, frames_in_use 5, drop_percent 20.
module multi_frame_pixel_fuse_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input beat
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mfpf_pkg::IN_W-1:0]      s_tdata,   // sample_0 [7:0] .. sample_7 [63:56]
    // result beat
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mfpf_pkg::OUT_W-1:0]     m_tdata,   // fused_value [7:0]
    // configuration
    input  logic                           cfg_we,
    input  logic [mfpf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mfpf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import mfpf_pkg::*;

    // configuration registers
    logic [1:0]       fuse_mode_reg;
    logic [CNT_W-1:0] frames_reg;
    logic [5:0]       drop_pct_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fuse_mode_reg <= RST_FUSE_MODE;
            frames_reg    <= RST_FRAMES;
            drop_pct_reg  <= RST_DROP_PCT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                IDX_FUSE_MODE: fuse_mode_reg <= cfg_wdata[1:0];
                IDX_FRAMES:    frames_reg    <= cfg_wdata[CNT_W-1:0];
                IDX_DROP_PCT:  drop_pct_reg  <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // derived settings
    logic [CNT_W-1:0] n_eff;
    logic [9:0]       pct_x_n;
    logic [2:0]       t_pct;
    logic [2:0]       t_bound;
    logic [2:0]       t_trim;
    logic [2:0]       t_sel;
    logic [CNT_W-1:0] cnt_w;
    drv_t             drv_next;
    drv_t             drv_reg;

    always_comb begin
        // saturate frame count
        priority if (frames_reg < 4'd2) n_eff = 4'd2;
        else if (frames_reg > CNT_W'(MAX_FRAMES)) n_eff = CNT_W'(MAX_FRAMES);
        else n_eff = frames_reg;

        // floor(pct * N / 100), product is at most 504
        pct_x_n = 10'(drop_pct_reg) * 10'(n_eff);
        priority if (pct_x_n >= 10'd500) t_pct = 3'd5;
        else if (pct_x_n >= 10'd400) t_pct = 3'd4;
        else if (pct_x_n >= 10'd300) t_pct = 3'd3;
        else if (pct_x_n >= 10'd200) t_pct = 3'd2;
        else if (pct_x_n >= 10'd100) t_pct = 3'd1;
        else t_pct = 3'd0;

        // clamp to [1, N/2 - 1]
        t_bound = n_eff[3:1] - 3'd1;
        t_trim  = (t_pct < 3'd1) ? 3'd1 : t_pct;
        if (t_trim > t_bound) t_trim = t_bound;
        t_sel = (fuse_mode_reg == MODE_TRIMMED) ? t_trim : 3'd0;
        cnt_w = n_eff - {t_sel, 1'b0};

        drv_next.median = (fuse_mode_reg == MODE_MEDIAN);
        drv_next.lo     = CNT_W'(t_sel);
        drv_next.hi     = CNT_W'(t_sel) + cnt_w;
        drv_next.cnt    = cnt_w;
        drv_next.half   = n_eff[3:1];
        drv_next.recip  = recip_of(cnt_w);
    end

    always_ff @(posedge aclk) begin
        drv_reg <= drv_next;
    end

    // pipeline handshake
    logic      v0_reg, v3_reg, v4_reg, v5_reg;
    logic      rdy0, rdy3, rdy4, rdy5;
    logic      srt_in_ready;
    logic      srt_valid;
    samp_vec_t srt_data;

    assign rdy5     = !v5_reg || m_tready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy0     = !v0_reg || srt_in_ready;
    assign s_tready = rdy0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy0) v0_reg <= s_tvalid;
            if (rdy3) v3_reg <= srt_valid;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // stage 0: capture, unused frames forced to full scale so they sort last
    samp_vec_t s0_next;
    samp_vec_t s0_reg;

    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            s0_next[i] = (CNT_W'(i) < n_eff) ? s_tdata[i*SAMP_W +: SAMP_W] : '1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy0 && s_tvalid) s0_reg <= s0_next;
    end

    // stages 1-2: sorting network
    mfpf_sort u_sort (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v0_reg),
        .in_ready  (srt_in_ready),
        .in_data   (s0_reg),
        .out_valid (srt_valid),
        .out_ready (rdy3),
        .out_data  (srt_data)
    );

    // stage 3: windowed sum and median pick
    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  sum3_reg;
    logic [SAMP_W-1:0] med3_reg;

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (CNT_W'(i) >= drv_reg.lo && CNT_W'(i) < drv_reg.hi) begin
                sum_next = sum_next + SUM_W'(srt_data[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && srt_valid) begin
            sum3_reg <= sum_next;
            med3_reg <= srt_data[drv_reg.half];
        end
    end

    // stage 4: floor quotient by reciprocal multiply
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [SUM_W-1:0]         q4_reg;
    logic [SUM_W-1:0]         sum4_reg;
    logic [SAMP_W-1:0]        med4_reg;

    assign prod = (SUM_W+RECIP_W)'(sum3_reg) * (SUM_W+RECIP_W)'(drv_reg.recip);

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            q4_reg   <= prod[RECIP_SH +: SUM_W];
            sum4_reg <= sum3_reg;
            med4_reg <= med3_reg;
        end
    end

    // stage 5: remainder, round half to even, clamp, mode select
    logic [SUM_W+CNT_W-1:0] qd;
    logic [SUM_W-1:0]       rem_full;
    logic [CNT_W-1:0]       rem;
    logic [CNT_W:0]         rem2;
    logic                   round_up;
    logic [SUM_W:0]         q_rnd;
    logic [SAMP_W-1:0]      avg;
    logic [SAMP_W-1:0]      res_reg;

    always_comb begin
        qd       = (SUM_W+CNT_W)'(q4_reg) * (SUM_W+CNT_W)'(drv_reg.cnt);
        rem_full = sum4_reg - qd[SUM_W-1:0];
        rem      = rem_full[CNT_W-1:0];
        rem2     = {rem, 1'b0};
        round_up = (rem2 > {1'b0, drv_reg.cnt}) ||
                   ((rem2 == {1'b0, drv_reg.cnt}) && q4_reg[0]);
        q_rnd    = (SUM_W+1)'(q4_reg) + (SUM_W+1)'(round_up);
        avg      = (q_rnd > (SUM_W+1)'(255)) ? 8'hFF : q_rnd[SAMP_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (rdy5 && v4_reg) begin
            res_reg <= drv_reg.median ? med4_reg : avg;
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = res_reg;

    // remainder of the floor quotient is below the divisor
    property p_rem_range;
        @(posedge aclk) disable iff (!aresetn)
        v4_reg |-> (rem_full < SUM_W'(drv_reg.cnt));
    endproperty
    a_rem_range: assert property (p_rem_range) else $error("reciprocal quotient off by one");

    // a held result beat blocks stage 4 from overwriting
    property p_stage4_hold;
        @(posedge aclk) disable iff (!aresetn)
        v4_reg && v5_reg && !m_tready |=> v4_reg && $stable(q4_reg) && $stable(sum4_reg);
    endproperty
    a_stage4_hold: assert property (p_stage4_hold) else $error("stage 4 beat lost on stall");

    // input back-pressure only when the front stage is occupied
    property p_ready_full;
        @(posedge aclk) disable iff (!aresetn)
        !s_tready |-> v0_reg && !srt_in_ready;
    endproperty
    a_ready_full: assert property (p_ready_full) else $error("input stalled with room");

endmodule

### rtl/mfpf_sort.sv
// Two-stage pipelined odd-even merge sorter for eight 8-bit samples.
// Each stage holds three comparator layers; valid/ready per stage.
// Depends on mfpf_pkg.
module mfpf_sort (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  mfpf_pkg::samp_vec_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output mfpf_pkg::samp_vec_t out_data
);
    import mfpf_pkg::*;

    samp_vec_t mid_reg;
    logic      mid_valid_reg;
    samp_vec_t out_reg;
    logic      out_valid_reg;
    logic      rdy_mid;
    logic      rdy_out;

    // stage loads when empty or when its content moves on
    assign rdy_out  = !out_valid_reg || out_ready;
    assign rdy_mid  = !mid_valid_reg || rdy_out;
    assign in_ready = rdy_mid;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rdy_mid) mid_valid_reg <= in_valid;
            if (rdy_out) out_valid_reg <= mid_valid_reg;
        end
    end

    // comparator layers
    always_ff @(posedge aclk) begin
        if (rdy_mid && in_valid)      mid_reg <= sort_front(in_data);
        if (rdy_out && mid_valid_reg) out_reg <= sort_back(mid_reg);
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // sorted output is ascending
    property p_ascending;
        @(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg[0] <= out_reg[1]) && (out_reg[1] <= out_reg[2]) &&
                          (out_reg[2] <= out_reg[3]) && (out_reg[3] <= out_reg[4]) &&
                          (out_reg[4] <= out_reg[5]) && (out_reg[5] <= out_reg[6]) &&
                          (out_reg[6] <= out_reg[7]);
    endproperty
    a_ascending: assert property (p_ascending) else $error("sorter output not ascending");

    // a full middle stage with a blocked output keeps its beat
    property p_mid_hold;
        @(posedge aclk) disable iff (!aresetn)
        mid_valid_reg && !rdy_out |=> mid_valid_reg && $stable(mid_reg);
    endproperty
    a_mid_hold: assert property (p_mid_hold) else $error("sorter middle stage lost a beat");

endmodule

### sim/mfpf_result_checker.sv
// Result checker for the multi-frame pixel fuse core: follows register writes, predicts
// each fused byte from accepted input beats and compares it with the output beats.
// Depends on mfpf_pkg for widths, register indexes, mode codes and reset values.
`timescale 1ns / 1ps

module mfpf_result_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mfpf_pkg::IN_W-1:0]       s_tdata,        // sample_0 [7:0] .. sample_7 [63:56]
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mfpf_pkg::OUT_W-1:0]      m_tdata,        // fused_value [7:0]
    input  logic                            cfg_we,
    input  logic [mfpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mfpf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic [31:0]                     fused_pending,  // predictions not yet matched
    output logic [31:0]                     mismatch_count
);
    import mfpf_pkg::*;

    logic [1:0]       mode_q;
    logic [CNT_W-1:0] frames_q;
    logic [5:0]       pct_q;
    logic [7:0]       fused_q [$];
    logic [7:0]       want;
    int unsigned      fails = 0;

    // Fused byte for one pixel channel under the given register values
    function automatic logic [7:0] predict_fused(samp_vec_t s, logic [1:0] mode,
                                                 logic [CNT_W-1:0] frames, logic [5:0] pct);
        int unsigned v [MAX_FRAMES];
        int unsigned n, t, bound, sum, cnt, q, r, x, lo, hi;
        int          i, j;
        n = frames;
        if (n < 2) n = 2;
        if (n > MAX_FRAMES) n = MAX_FRAMES;
        for (i = 0; i < n; i++) v[i] = s[i];
        // ascending insertion sort of the samples in use
        if (mode == MODE_MEDIAN || mode == MODE_TRIMMED) begin
            for (i = 1; i < n; i++) begin
                x = v[i];
                j = i;
                while (j > 0 && v[j-1] > x) begin
                    v[j] = v[j-1];
                    j--;
                end
                v[j] = x;
            end
        end
        if (mode == MODE_MEDIAN) return 8'(v[n/2]);
        lo = 0;
        hi = n;
        if (mode == MODE_TRIMMED) begin
            bound = n / 2 - 1;
            t = (pct * n) / 100;
            if (t < 1) t = 1;
            if (t > bound) t = bound;
            lo = t;
            hi = n - t;
        end
        sum = 0;
        for (i = lo; i < hi; i++) sum += v[i];
        cnt = hi - lo;
        q = sum / cnt;
        r = sum % cnt;
        // round to nearest, ties to even
        if (2 * r > cnt || (2 * r == cnt && q[0])) q++;
        if (q > 255) q = 255;
        return q[7:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            fused_q.delete();
            mode_q   = RST_FUSE_MODE;
            frames_q = RST_FRAMES;
            pct_q    = RST_DROP_PCT;
        end else begin
            // the bench must make register writes only while the pipe is empty; they are applied here unchecked
            if (cfg_we) begin
                case (cfg_index)
                    IDX_FUSE_MODE: mode_q   = cfg_wdata[1:0];
                    IDX_FRAMES:    frames_q = cfg_wdata[CNT_W-1:0];
                    IDX_DROP_PCT:  pct_q    = cfg_wdata[5:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                fused_q = {fused_q, predict_fused(s_tdata, mode_q, frames_q, pct_q)};
            if (m_tvalid && m_tready) begin
                if (fused_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result beat, expected none, actual fused_value %0d",
                             $time, m_tdata);
                end else begin
                    want = fused_q.pop_front();
                    if (m_tdata !== want) begin
                        fails++;
                        $display("%0t: fused_value mismatch, expected %0d, actual %0d",
                                 $time, want, m_tdata);
                    end
                end
            end
        end
        fused_pending  <= fused_q.size();
        mismatch_count <= fails;
    end

endmodule

### sim/multi_frame_pixel_fuse_core_test.sv
// Testbench top for multi_frame_pixel_fuse_core: drives directed and random pixel beats
// under changing register settings and idle patterns, and reports the verdict.
// Depends on mfpf_pkg, the core RTL and mfpf_result_checker.
`timescale 1ns / 1ps

module multi_frame_pixel_fuse_core_test;
    import mfpf_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 8;     // wait after draining, longer than the core's pipeline latency
    localparam int PHASE_BEATS = 634;
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED  = 2'd3;
    localparam logic [1:0]           MODE_UNUSED = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic [31:0]           fused_pending;
    logic [31:0]           mismatch_count;

    int send_idle = 14;
    int recv_idle = 83;
    int cycle_count = 0;

    multi_frame_pixel_fuse_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    mfpf_result_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .fused_pending  (fused_pending),
        .mismatch_count (mismatch_count)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Receiver back-pressure
    always @(posedge aclk) m_tready <= ($urandom_range(99) >= recv_idle);

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // One pixel beat, with an occasional idle gap ahead of it
    task automatic send_beat(input samp_vec_t d);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold off the sender until every prediction has been matched
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (fused_pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [5:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    // Write all three registers back to back on an idle core
    task automatic configure(input logic [5:0] mode_w, input logic [5:0] frames_w,
                             input logic [5:0] pct_w);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= IDX_FUSE_MODE;
        cfg_wdata <= mode_w;
        @(posedge aclk);
        cfg_index <= IDX_FRAMES;
        cfg_wdata <= frames_w;
        @(posedge aclk);
        cfg_index <= IDX_DROP_PCT;
        cfg_wdata <= pct_w;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_setting();
        logic [5:0] mode_w, frames_w, pct_w;
        mode_w = {4'($urandom_range(15)), 2'($urandom_range(3))};
        if ($urandom_range(99) < 85)
            frames_w = {2'($urandom_range(3)), 4'($urandom_range(2, MAX_FRAMES))};
        else
            frames_w = 6'($urandom_range(63));
        pct_w = ($urandom_range(99) < 80) ? 6'($urandom_range(50))
                                          : 6'($urandom_range(51, 63));
        configure(mode_w, frames_w, pct_w);
    endtask

    // Random pixel: plain noise, extremes, tight clusters with repeats, or outliers
    function automatic samp_vec_t random_pixel();
        samp_vec_t p;
        int        base, k, kind;
        kind = $urandom_range(3);
        base = $urandom_range(255);
        for (k = 0; k < MAX_FRAMES; k++) begin
            case (kind)
                0: p[k] = 8'($urandom_range(255));
                1: p[k] = ($urandom_range(2) == 0) ? 8'($urandom_range(255))
                                                   : ($urandom_range(1) ? 8'hFF : 8'h00);
                2: begin
                    base = base + $urandom_range(6) - 3;
                    if (base < 0) base = 0;
                    if (base > 255) base = 255;
                    p[k] = 8'(base);
                end
                default: p[k] = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'(base);
            endcase
        end
        return p;
    endfunction

    task automatic random_phase(input int beats);
        int left, chunk, i;
        left = beats;
        while (left > 0) begin
            random_setting();
            chunk = $urandom_range(30, 110);
            if (chunk > left) chunk = left;
            for (i = 0; i < chunk; i++) begin
                if ($urandom_range(149) == 0) drain();
                send_beat(random_pixel());
            end
            left -= chunk;
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= IDX_FUSE_MODE;
        cfg_wdata <= '0;
        repeat (8) @(posedge aclk);
        aresetn   <= 1'b1;
        @(posedge aclk);

        // Reset settings: mean of five, the upper three samples play no part
        send_beat(64'h0000_0000_0000_0000);
        send_beat(64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(64'hFFFF_FF00_0000_0000);
        send_beat(64'h0000_00FF_8040_7F01);

        // Median of eight, upper median on a split set
        configure({4'd0, MODE_MEDIAN}, 6'd8, 6'd20);
        send_beat(64'h0001_0203_0405_0607);
        send_beat(64'hFF00_FF00_FF00_FF00);

        // Mean of two: ties go to even
        configure({4'd0, MODE_MEAN}, 6'd2, 6'd20);
        send_beat(64'hFFFF_FFFF_FFFF_0001);
        send_beat(64'h0000_0000_0000_0201);
        send_beat(64'h0000_0000_0000_FFFE);

        // Unused mode code acts as mean; frame count zero saturates to two
        configure({4'hF, MODE_UNUSED}, 6'h30, 6'd63);
        send_beat(64'hAAAA_AAAA_AAAA_0301);

        // Trimmed, frame count above eight saturates, zero percent still trims one
        configure({4'd0, MODE_TRIMMED}, 6'd15, 6'd0);
        send_beat(64'hFF00_0000_0000_00FF);
        send_beat(64'h0102_0304_0506_0708);

        // Trimmed at fifty percent and above: bound keeps two samples
        configure({4'd0, MODE_TRIMMED}, 6'd8, 6'd50);
        send_beat(64'h00FF_0180_7F02_FE03);
        send_beat(64'hFFFF_FFFF_FFFF_FFFF);
        configure({4'd0, MODE_TRIMMED}, 6'd8, 6'd63);
        send_beat(64'h1020_3040_5060_7080);

        // Small counts: no trim at three or two frames; then trimmed seven and six frames
        configure({4'd0, MODE_TRIMMED}, 6'd3, 6'd50);
        send_beat(64'hFFFF_FFFF_FF00_0102);
        configure({4'd0, MODE_TRIMMED}, 6'd2, 6'd0);
        send_beat(64'h0000_0000_0000_FF01);
        configure({4'd0, MODE_MEDIAN}, 6'd2, 6'd0);
        send_beat(64'h0000_0000_0000_0305);
        configure({4'd0, MODE_TRIMMED}, 6'd7, 6'd49);
        send_beat(64'h00FF_10F0_2080_4001);
        configure({4'd0, MODE_TRIMMED}, 6'd6, 6'd30);
        send_beat(64'h5555_0AFF_0064_C801);

        // Write to the unused register index must change nothing
        write_one(IDX_UNUSED, 6'h3F);
        send_beat(64'h0000_0000_0000_0203);

        configure({4'd0, MODE_MEAN}, 6'd8, 6'd0);
        send_beat(64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(64'hAA55_AA55_AA55_AA55);

        // Random part under three idle patterns
        random_phase(PHASE_BEATS);
        drain();
        send_idle = 83;
        recv_idle = 14;
        random_phase(PHASE_BEATS);
        drain();
        send_idle = 0;
        recv_idle = 0;
        random_phase(PHASE_BEATS);

        drain();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
